FILE: src/rvf_pkg.sv
// rvf_pkg: types and constants for the radial vignette feather block
// no dependencies; imported by src/radial_vignette_feather.sv
package rvf_pkg;

  localparam int COORD_BITS      = 13;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int CH_BITS         = 8;
  localparam int DIST_FRAC       = 8;

  // squared distance and square root sizes
  localparam int D2_BITS    = 2 * COORD_BITS + 1;
  localparam int SQ_IN_BITS = D2_BITS + 2 * DIST_FRAC;
  localparam int SQ_STEPS   = (SQ_IN_BITS + 1) / 2;
  localparam int SQ_PAD     = 2 * SQ_STEPS;
  localparam int ROOT_BITS  = SQ_STEPS;
  localparam int SQ_REM     = ROOT_BITS + 2;

  // division sizes: quotient bits up to and including the value one
  localparam int DVD_BITS  = ROOT_BITS + ALPHA_FRAC_BITS - DIST_FRAC;
  localparam int DIV_STEPS = ALPHA_FRAC_BITS + 1;
  localparam int DIV_REM   = COORD_BITS + 1;
  localparam int CMP_BITS  = DVD_BITS + COORD_BITS + DIV_STEPS;
  localparam int KEEP_BITS = ALPHA_FRAC_BITS + 1;
  localparam int PROD_BITS = CH_BITS + KEEP_BITS;

  localparam logic [KEEP_BITS-1:0] ALPHA_ONE = KEEP_BITS'(1) << ALPHA_FRAC_BITS;

  // input, diff, square, sum, root steps, range check, divide steps, alpha, scale
  localparam int PIPE_DEPTH = 4 + SQ_STEPS + 1 + DIV_STEPS + 2;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FEATHER_ENABLE = 3'd0,
    CFG_CENTER_COL     = 3'd1,
    CFG_CENTER_ROW     = 3'd2,
    CFG_FADE_RADIUS    = 3'd3,
    CFG_BAND_TOP_ROW   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [CH_BITS-1:0]    chan_blue;
    logic [CH_BITS-1:0]    chan_green;
    logic [CH_BITS-1:0]    chan_red;
  } pixel_t;

  typedef struct packed {
    logic [CH_BITS-1:0] out_blue;
    logic [CH_BITS-1:0] out_green;
    logic [CH_BITS-1:0] out_red;
  } result_t;

  // channels and the darken flag ride along the pipe
  typedef struct packed {
    logic               active;
    logic [CH_BITS-1:0] blue;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] red;
  } side_t;

endpackage

FILE: src/radial_vignette_feather.sv
// radial_vignette_feather: pipelined radial darkening of a bottom image band
// an accepted start passes the input, diff, square, sum, root, range, divide, alpha and scale stages to done;
// one pixel per cycle while busy is low, no stall inside the pipe; depth set by the 22-step square root pipe
// and the 17-step divider pipe; reset clears all valid bits and loads register defaults (radius 1, rest 0)
// busy is a registered copy of rst, high during reset and in the cycle after it; done cannot be held off
// depends on src/rvf_pkg.sv
module radial_vignette_feather (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  rvf_pkg::pixel_t                     pixel,
  output logic                                done,
  output rvf_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [rvf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rvf_pkg::COORD_BITS-1:0]      cfg_data
);
  import rvf_pkg::*;

  logic                  feather_enable;
  logic [COORD_BITS-1:0] center_col;
  logic [COORD_BITS-1:0] center_row;
  logic [COORD_BITS-1:0] fade_radius;
  logic [COORD_BITS-1:0] band_top_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      feather_enable <= 1'b0;
      center_col     <= '0;
      center_row     <= '0;
      fade_radius    <= COORD_BITS'(1);
      band_top_row   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FEATHER_ENABLE: feather_enable <= cfg_data[0];
        CFG_CENTER_COL:     center_col     <= cfg_data;
        CFG_CENTER_ROW:     center_row     <= cfg_data;
        CFG_FADE_RADIUS:    fade_radius    <= cfg_data;
        CFG_BAND_TOP_ROW:   band_top_row   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic accept;
  assign accept = start && !busy;

  // stage 0: capture
  logic                  v0;
  logic [COORD_BITS-1:0] col0, row0;
  side_t                 side0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= accept;
  end

  always_ff @(posedge clk) begin
    col0         <= pixel.pixel_col;
    row0         <= pixel.pixel_row;
    side0.active <= feather_enable && (pixel.pixel_row >= band_top_row);
    side0.blue   <= pixel.chan_blue;
    side0.green  <= pixel.chan_green;
    side0.red    <= pixel.chan_red;
  end

  // stage 1: distances to the center
  logic                  v1;
  logic [COORD_BITS-1:0] dx1, dy1;
  side_t                 side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
  end

  always_ff @(posedge clk) begin
    dx1   <= (col0 >= center_col) ? col0 - center_col : center_col - col0;
    dy1   <= (row0 >= center_row) ? row0 - center_row : center_row - row0;
    side1 <= side0;
  end

  // stage 2: squares
  logic                    v2;
  logic [2*COORD_BITS-1:0] sqx2, sqy2;
  side_t                   side2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    sqx2  <= (2*COORD_BITS)'(dx1) * (2*COORD_BITS)'(dx1);
    sqy2  <= (2*COORD_BITS)'(dy1) * (2*COORD_BITS)'(dy1);
    side2 <= side1;
  end

  // stage 3: squared distance
  logic               v3;
  logic [D2_BITS-1:0] d2_3;
  side_t              side3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    d2_3  <= D2_BITS'(sqx2) + D2_BITS'(sqy2);
    side3 <= side2;
  end

  // square root of d2 scaled by 2^16, one result bit per stage
  logic                 sq_v    [SQ_STEPS];
  logic [SQ_PAD-1:0]    sq_n    [SQ_STEPS];
  logic [ROOT_BITS-1:0] sq_root [SQ_STEPS];
  logic [SQ_REM-1:0]    sq_rem  [SQ_STEPS];
  side_t                sq_side [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    logic                 in_v;
    logic [SQ_PAD-1:0]    in_n;
    logic [ROOT_BITS-1:0] in_root;
    logic [SQ_REM-1:0]    in_rem;
    side_t                in_side;
    logic [SQ_REM-1:0]    rem_sh;
    logic [SQ_REM-1:0]    trial;
    logic                 ge;

    if (j == 0) begin : g_first
      assign in_v    = v3;
      assign in_n    = SQ_PAD'({d2_3, {(2 * DIST_FRAC){1'b0}}});
      assign in_root = '0;
      assign in_rem  = '0;
      assign in_side = side3;
    end else begin : g_next
      assign in_v    = sq_v[j-1];
      assign in_n    = sq_n[j-1];
      assign in_root = sq_root[j-1];
      assign in_rem  = sq_rem[j-1];
      assign in_side = sq_side[j-1];
    end

    always_comb begin
      rem_sh = {in_rem[SQ_REM-3:0], in_n[SQ_PAD-1-2*j -: 2]};
      trial  = {in_root, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) sq_v[j] <= 1'b0;
      else     sq_v[j] <= in_v;
    end

    always_ff @(posedge clk) begin
      sq_n[j]    <= in_n;
      sq_root[j] <= {in_root[ROOT_BITS-2:0], ge};
      sq_rem[j]  <= ge ? rem_sh - trial : rem_sh;
      sq_side[j] <= in_side;
    end
  end

  // range stage: flags a zero radius or a quotient of two or more, either of which saturates alpha
  logic                v4;
  logic                ovf4;
  logic [DVD_BITS-1:0] dvd4;
  logic [DIV_REM-1:0]  rem4;
  side_t               side4;
  logic [DVD_BITS-1:0] dvd_in;

  assign dvd_in = DVD_BITS'({sq_root[SQ_STEPS-1], {(ALPHA_FRAC_BITS - DIST_FRAC){1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= sq_v[SQ_STEPS-1];
  end

  always_ff @(posedge clk) begin
    ovf4  <= (fade_radius == '0) ||
             (CMP_BITS'(dvd_in) >= (CMP_BITS'(fade_radius) << DIV_STEPS));
    dvd4  <= dvd_in;
    rem4  <= DIV_REM'(dvd_in >> DIV_STEPS);
    side4 <= sq_side[SQ_STEPS-1];
  end

  // restoring divider, one quotient bit per stage
  logic                 dv_v    [DIV_STEPS];
  logic                 dv_ovf  [DIV_STEPS];
  logic [DVD_BITS-1:0]  dv_dvd  [DIV_STEPS];
  logic [DIV_REM-1:0]   dv_rem  [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_q    [DIV_STEPS];
  side_t                dv_side [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic                 in_v;
    logic                 in_ovf;
    logic [DVD_BITS-1:0]  in_dvd;
    logic [DIV_REM-1:0]   in_rem;
    logic [DIV_STEPS-1:0] in_q;
    side_t                in_side;
    logic [DIV_REM-1:0]   rem_sh;
    logic [DIV_REM-1:0]   rad;
    logic                 ge;

    if (k == 0) begin : g_first
      assign in_v    = v4;
      assign in_ovf  = ovf4;
      assign in_dvd  = dvd4;
      assign in_rem  = rem4;
      assign in_q    = '0;
      assign in_side = side4;
    end else begin : g_next
      assign in_v    = dv_v[k-1];
      assign in_ovf  = dv_ovf[k-1];
      assign in_dvd  = dv_dvd[k-1];
      assign in_rem  = dv_rem[k-1];
      assign in_q    = dv_q[k-1];
      assign in_side = dv_side[k-1];
    end

    always_comb begin
      rem_sh = {in_rem[DIV_REM-2:0], in_dvd[DIV_STEPS-1-k]};
      rad    = DIV_REM'(fade_radius);
      ge     = (rem_sh >= rad);
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[k] <= 1'b0;
      else     dv_v[k] <= in_v;
    end

    always_ff @(posedge clk) begin
      dv_ovf[k]  <= in_ovf;
      dv_dvd[k]  <= in_dvd;
      dv_rem[k]  <= ge ? rem_sh - rad : rem_sh;
      dv_q[k]    <= {in_q[DIV_STEPS-2:0], ge};
      dv_side[k] <= in_side;
    end
  end

  // alpha stage: keep = one minus capped alpha
  logic                 v5;
  logic [KEEP_BITS-1:0] keep5;
  side_t                side5;
  logic [KEEP_BITS-1:0] quot;

  assign quot = KEEP_BITS'(dv_q[DIV_STEPS-1]);

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= dv_v[DIV_STEPS-1];
  end

  always_ff @(posedge clk) begin
    keep5 <= (dv_ovf[DIV_STEPS-1] || (quot > ALPHA_ONE)) ? '0 : ALPHA_ONE - quot;
    side5 <= dv_side[DIV_STEPS-1];
  end

  // scale stage, also the output register
  logic [PROD_BITS-1:0] prod_b, prod_g, prod_r;

  assign prod_b = PROD_BITS'(side5.blue)  * PROD_BITS'(keep5);
  assign prod_g = PROD_BITS'(side5.green) * PROD_BITS'(keep5);
  assign prod_r = PROD_BITS'(side5.red)   * PROD_BITS'(keep5);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v5;
  end

  always_ff @(posedge clk) begin
    if (side5.active) begin
      result.out_blue  <= prod_b[ALPHA_FRAC_BITS +: CH_BITS];
      result.out_green <= prod_g[ALPHA_FRAC_BITS +: CH_BITS];
      result.out_red   <= prod_r[ALPHA_FRAC_BITS +: CH_BITS];
    end else begin
      result.out_blue  <= side5.blue;
      result.out_green <= side5.green;
      result.out_red   <= side5.red;
    end
  end

`ifndef NO_ASSERTIONS
  // every result comes from an earlier accepted transaction, checked against PIPE_DEPTH
  a_done_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("done without a matching start");

  // darkening never brightens a channel
  a_no_brighten : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.out_blue  <= $past(pixel.chan_blue,  PIPE_DEPTH)) &&
             (result.out_green <= $past(pixel.chan_green, PIPE_DEPTH)) &&
             (result.out_red   <= $past(pixel.chan_red,   PIPE_DEPTH)))
    else $error("output channel above input channel");

  // reset flushes the pipe
  a_reset_flush : assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("done right after reset");
`endif

endmodule
